>>> design/mrac_pkg.sv
// ----------------------------------------------------------------------------
// mrac_pkg
// Shared types and constants for the memory region access checker: field
// widths, operation and status codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package mrac_pkg;

  localparam int OP_W   = 2;
  localparam int ADDR_W = 48;
  localparam int END_W  = 49;
  localparam int LEN_W  = 32;
  localparam int ST_W   = 2;
  localparam int IDX_W  = 4;

  // Operation codes
  localparam logic [OP_W-1:0] OP_REG    = 2'd0;
  localparam logic [OP_W-1:0] OP_RD     = 2'd1;
  localparam logic [OP_W-1:0] OP_WR     = 2'd2;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_MERGED = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd2;
  localparam logic [ST_W-1:0] ST_DENIED = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CACHE,
    S_SEARCH,
    S_APPLY,
    S_RESP
  } mrac_state_t;

  typedef struct packed {
    logic accept;        // capture the input beat
    logic cache_res;     // evaluate last-hit region, preload result
    logic search_start;  // clear the table walk
    logic search_step;   // issue one read, compare the previous one
    logic apply;         // commit table / cache / count update
    logic out_load;      // move result into the output register
  } mrac_cmd_t;

  typedef struct packed {
    logic skip_search;   // cache hit or unused op: result already known
    logic match;         // entry under compare holds start or end
    logic search_end;    // every valid entry has been issued
    logic out_free;      // output register can take a beat this cycle
  } mrac_sts_t;

endpackage

>>> design/mrac_ram.sv
// ----------------------------------------------------------------------------
// mrac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mrac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/mrac_ctrl.sv
// ----------------------------------------------------------------------------
// mrac_ctrl
// Sequencer for one item: capture, cache test, table walk, commit, respond.
// ----------------------------------------------------------------------------
module mrac_ctrl
  import mrac_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  mrac_sts_t sts,
  output mrac_cmd_t cmd
);

  mrac_state_t state_r;
  mrac_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CACHE;
        end
      end
      S_CACHE: begin
        cmd.cache_res = 1'b1;
        if (sts.skip_search) begin
          state_nxt = S_RESP;
        end else begin
          cmd.search_start = 1'b1;
          state_nxt        = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.search_step = 1'b1;
        if (sts.match || sts.search_end) begin
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> design/mrac_dp.sv
// ----------------------------------------------------------------------------
// mrac_dp
// Datapath: item registers, last-hit regions, region table RAM with walk
// counter, commit logic and output register.
// ----------------------------------------------------------------------------
module mrac_dp
  import mrac_pkg::*;
#(
  parameter int MAX_REGIONS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [OP_W-1:0]   in_op,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [LEN_W-1:0]  in_length,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [ST_W-1:0]   out_status,
  output logic [IDX_W-1:0]  out_match_index,
  output logic              out_cache_hit,
  input  mrac_cmd_t         cmd,
  output mrac_sts_t         sts
);

  localparam int IW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int RW = END_W + ADDR_W;

  // item
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [ADDR_W-1:0] lo_r, lo_nxt;
  logic [END_W-1:0]  hi_r, hi_nxt;

  // last-hit regions
  logic [ADDR_W-1:0] rc_start_r, rc_start_nxt;
  logic [END_W-1:0]  rc_end_r, rc_end_nxt;
  logic [ADDR_W-1:0] wc_start_r, wc_start_nxt;
  logic [END_W-1:0]  wc_end_r, wc_end_nxt;

  // table walk
  logic [CW-1:0]     count_r, count_nxt;
  logic [CW-1:0]     iss_r, iss_nxt;
  logic              pend_r, pend_nxt;
  logic [IW-1:0]     pend_idx_r, pend_idx_nxt;
  logic              found_r, found_nxt;
  logic [IW-1:0]     fidx_r, fidx_nxt;
  logic [ADDR_W-1:0] fstart_r, fstart_nxt;
  logic [END_W-1:0]  fend_r, fend_nxt;

  // pending result and output register
  logic [ST_W-1:0]   res_status_r, res_status_nxt;
  logic [IDX_W-1:0]  res_idx_r, res_idx_nxt;
  logic              res_hit_r, res_hit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]   out_status_r, out_status_nxt;
  logic [IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic              out_hit_r, out_hit_nxt;

  // RAM ports
  logic              ram_we;
  logic [IW-1:0]     ram_waddr;
  logic [RW-1:0]     ram_wdata;
  logic [IW-1:0]     ram_raddr;
  logic [RW-1:0]     ram_rdata;

  logic [ADDR_W-1:0] rd_start;
  logic [END_W-1:0]  rd_end;
  logic              span_hit;
  logic              is_chk;
  logic              is_wr;
  logic              chit;
  logic [ADDR_W-1:0] cs;
  logic [END_W-1:0]  ce;
  logic [ADDR_W-1:0] mg_start;
  logic [END_W-1:0]  mg_end;
  logic              straddle;
  logic [IW+IDX_W-1:0] fidx_ext;

  mrac_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_REGIONS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_start = ram_rdata[ADDR_W-1:0];
  assign rd_end   = ram_rdata[RW-1:ADDR_W];
  assign span_hit = (({1'b0, lo_r} >= {1'b0, rd_start}) && ({1'b0, lo_r} <= rd_end)) ||
                    ((hi_r >= {1'b0, rd_start}) && (hi_r <= rd_end));

  assign is_wr  = (op_r == OP_WR);
  assign is_chk = (op_r == OP_RD) || (op_r == OP_WR);
  assign cs     = is_wr ? wc_start_r : rc_start_r;
  assign ce     = is_wr ? wc_end_r : rc_end_r;
  assign chit   = (lo_r >= cs) && (hi_r <= ce);

  assign mg_start = (lo_r < fstart_r) ? lo_r : fstart_r;
  assign mg_end   = (hi_r > fend_r) ? hi_r : fend_r;
  assign straddle = (lo_r < fstart_r) && (hi_r > fend_r);
  assign fidx_ext = {{IDX_W{1'b0}}, fidx_r};

  assign ram_raddr = iss_r[IW-1:0];

  assign sts.skip_search = (op_r == OP_UNUSED) || (is_chk && chit);
  assign sts.match       = pend_r && span_hit;
  assign sts.search_end  = (iss_r == count_r);
  assign sts.out_free    = !out_valid_r || !out_stall;

  always_comb begin
    op_nxt         = op_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    rc_start_nxt   = rc_start_r;
    rc_end_nxt     = rc_end_r;
    wc_start_nxt   = wc_start_r;
    wc_end_nxt     = wc_end_r;
    count_nxt      = count_r;
    iss_nxt        = iss_r;
    pend_nxt       = pend_r;
    pend_idx_nxt   = pend_idx_r;
    found_nxt      = found_r;
    fidx_nxt       = fidx_r;
    fstart_nxt     = fstart_r;
    fend_nxt       = fend_r;
    res_status_nxt = res_status_r;
    res_idx_nxt    = res_idx_r;
    res_hit_nxt    = res_hit_r;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_hit_nxt    = out_hit_r;
    out_valid_nxt  = out_valid_r && out_stall;
    ram_we         = 1'b0;
    ram_waddr      = fidx_r;
    ram_wdata      = {mg_end, mg_start};

    if (cmd.accept) begin
      op_nxt = in_op;
      lo_nxt = in_address;
      hi_nxt = {1'b0, in_address} + END_W'(in_length);
    end

    if (cmd.cache_res) begin
      res_status_nxt = ST_OK;
      res_idx_nxt    = '0;
      res_hit_nxt    = is_chk && chit;
    end

    if (cmd.search_start) begin
      iss_nxt   = '0;
      pend_nxt  = 1'b0;
      found_nxt = 1'b0;
    end

    if (cmd.search_step) begin
      // issue the next entry while the previous one is compared
      if (iss_r != count_r) begin
        iss_nxt      = iss_r + CW'(1);
        pend_nxt     = 1'b1;
        pend_idx_nxt = iss_r[IW-1:0];
      end else begin
        pend_nxt = 1'b0;
      end
      if (pend_r && span_hit) begin
        found_nxt  = 1'b1;
        fidx_nxt   = pend_idx_r;
        fstart_nxt = rd_start;
        fend_nxt   = rd_end;
      end
    end

    if (cmd.apply) begin
      res_hit_nxt    = 1'b0;
      res_idx_nxt    = '0;
      res_status_nxt = ST_OK;
      if (op_r == OP_REG) begin
        if (found_r) begin
          ram_we         = 1'b1;
          res_status_nxt = ST_MERGED;
          res_idx_nxt    = fidx_ext[IDX_W-1:0];
        end else if (count_r < CW'(MAX_REGIONS)) begin
          ram_we    = 1'b1;
          ram_waddr = count_r[IW-1:0];
          ram_wdata = {hi_r, lo_r};
          count_nxt = count_r + CW'(1);
        end else begin
          res_status_nxt = ST_FULL;
        end
      end else if (!found_r || straddle) begin
        res_status_nxt = ST_DENIED;
      end else begin
        res_idx_nxt = fidx_ext[IDX_W-1:0];
        if (is_wr) begin
          wc_start_nxt = fstart_r;
          wc_end_nxt   = fend_r;
        end else begin
          rc_start_nxt = fstart_r;
          rc_end_nxt   = fend_r;
        end
      end
    end

    if (cmd.out_load) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = res_status_r;
      out_idx_nxt    = res_idx_r;
      out_hit_nxt    = res_hit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_start_r  <= '0;
      rc_end_r    <= '0;
      wc_start_r  <= '0;
      wc_end_r    <= '0;
      count_r     <= '0;
      iss_r       <= '0;
      pend_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rc_start_r  <= rc_start_nxt;
      rc_end_r    <= rc_end_nxt;
      wc_start_r  <= wc_start_nxt;
      wc_end_r    <= wc_end_nxt;
      count_r     <= count_nxt;
      iss_r       <= iss_nxt;
      pend_r      <= pend_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    pend_idx_r   <= pend_idx_nxt;
    fidx_r       <= fidx_nxt;
    fstart_r     <= fstart_nxt;
    fend_r       <= fend_nxt;
    res_status_r <= res_status_nxt;
    res_idx_r    <= res_idx_nxt;
    res_hit_r    <= res_hit_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_hit_r    <= out_hit_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_match_index = out_idx_r;
  assign out_cache_hit   = out_hit_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_REGIONS))
    else $error("region count above table depth");

  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    iss_r <= count_r)
    else $error("table walk ran past valid entries");

  a_hit_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_hit_r) |-> (out_status_r == ST_OK && out_idx_r == '0))
    else $error("cache hit beat carries status or index");
`endif

endmodule

>>> design/memory_region_access_checker_top.sv
// ----------------------------------------------------------------------------
// memory_region_access_checker_top
// Region table with per-direction last-hit regions: registers address
// regions (merge or append) and checks read / write accesses against them.
// ----------------------------------------------------------------------------
//
//  channel  direction  ports                                         beat
//  -------  ---------  --------------------------------------------  -----------
//  in_      input      in_valid in_stall in_op in_address in_length  one item
//  out_     output     out_valid out_stall out_status                one result
//                      out_match_index out_cache_hit
//
//  One item at a time. A check that hits its last-hit region, or an unused
//  op, goes from the cache test straight to the respond step; otherwise
//  the walk of the region table RAM (one read port, one entry per cycle)
//  sets the cost: it reads up to region_count entries, at most MAX_REGIONS.
//  Reset clears the region count and both last-hit regions; no sweep of the
//  table is needed, since only entries below the count are read.
//  A finished result waits in the output register under out_stall while the
//  next item is accepted; the sequencer holds in its respond step only if
//  the output register is still occupied.
//
module memory_region_access_checker_top
  import mrac_pkg::*;
#(
  parameter int MAX_REGIONS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_op,
  input  logic [ADDR_W-1:0] in_address,
  input  logic [LEN_W-1:0]  in_length,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ST_W-1:0]   out_status,
  output logic [IDX_W-1:0]  out_match_index,
  output logic              out_cache_hit
);

  // command and status bundles between sequencer and datapath
  mrac_cmd_t cmd;
  mrac_sts_t sts;

  // Sequencer: advance one item through cache test, walk, commit, respond.
  mrac_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: hold item, table RAM, last-hit regions and output register.
  mrac_dp #(
    .MAX_REGIONS (MAX_REGIONS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_op),
    .in_address      (in_address),
    .in_length       (in_length),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_match_index (out_match_index),
    .out_cache_hit   (out_cache_hit),
    .cmd             (cmd),
    .sts             (sts)
  );

endmodule
